// ===== hdl/owm_pkg.sv =====
package owm_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  typedef logic [NumRegs-1:0][CfgW-1:0] cfg_t;

  // register indexes on the configuration port
  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_RELEASE = 3'd0,
    REG_RESET_LOW     = 3'd1,
    REG_PRESENCE_WAIT = 3'd2,
    REG_SLOT_START    = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_SLOT_RECOVERY = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_e;

  localparam cfg_t CfgReset = {
    10'd35,   // read tail
    10'd10,   // read sample
    10'd5,    // slot recovery
    10'd95,   // write hold
    10'd5,    // slot start
    10'd50,   // presence wait
    10'd500,  // reset low
    10'd500   // reset release
  };

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_REL  = 4'd1,
    PH_RST_LOW  = 4'd2,
    PH_RST_WAIT = 4'd3,
    PH_W_LOW    = 4'd4,
    PH_W_HOLD   = 4'd5,
    PH_W_REC    = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_WAIT   = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] read_result;
    logic       presence;
  } eng_state_t;

  typedef struct packed {
    logic       presence;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

endpackage

// ===== hdl/owm_core.sv =====
module owm_core #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  owm_pkg::eng_state_t  state_i,
  input  logic [TIMER_BITS-1:0] timer_i,
  input  owm_pkg::cfg_t        cfg_i,
  input  logic [1:0]           op_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_in_i,
  output owm_pkg::eng_state_t  state_o,
  output logic [TIMER_BITS-1:0] timer_o,
  output owm_pkg::result_t     result_o
);
  import owm_pkg::*;

  // compare width covers both the timer range and the register range
  localparam int unsigned CmpW = ((TIMER_BITS > CfgW) ? TIMER_BITS : CfgW) + 1;

  eng_state_t              st;
  logic [TIMER_BITS-1:0]   tmr;
  logic [CfgW-1:0]         dur_raw;
  logic [CmpW-1:0]         dur;
  logic [CmpW-1:0]         limit;
  logic                    phase_end;
  logic                    drive;
  logic                    busy;
  logic                    done;

  always_comb begin
    st   = state_i;
    tmr  = timer_i;
    drive = 1'b0;
    busy  = 1'b0;
    done  = 1'b0;
    dur_raw = cfg_i[REG_READ_TAIL];
    dur   = '0;
    limit = CmpW'(1) << TIMER_BITS;
    phase_end = 1'b0;

    // a command starts on the tick it arrives
    if (st.phase == PH_IDLE) begin
      case (op_e'(op_i))
        OP_RESET: begin
          st.phase = PH_RST_REL;
        end
        OP_WRITE: begin
          st.phase      = PH_W_LOW;
          st.shift_byte = write_data_i;
        end
        OP_READ: begin
          st.phase      = PH_R_LOW;
          st.shift_byte = 8'h00;
        end
        default: ;
      endcase
      if (op_e'(op_i) != OP_TICK) begin
        tmr          = '0;
        st.bit_index = 3'd0;
      end
    end

    case (st.phase)
      PH_RST_REL:            dur_raw = cfg_i[REG_RESET_RELEASE];
      PH_RST_LOW:            dur_raw = cfg_i[REG_RESET_LOW];
      PH_RST_WAIT:           dur_raw = cfg_i[REG_PRESENCE_WAIT];
      PH_W_LOW, PH_R_LOW:    dur_raw = cfg_i[REG_SLOT_START];
      PH_W_HOLD:             dur_raw = cfg_i[REG_WRITE_HOLD];
      PH_W_REC:              dur_raw = cfg_i[REG_SLOT_RECOVERY];
      PH_R_WAIT:             dur_raw = cfg_i[REG_READ_SAMPLE];
      default:               dur_raw = cfg_i[REG_READ_TAIL];
    endcase

    // zero counts as one tick, anything past the timer range is clipped
    dur = CmpW'(dur_raw);
    if (dur == '0) begin
      dur = CmpW'(1);
    end
    if (dur > limit) begin
      dur = limit;
    end
    phase_end = (CmpW'(tmr) + CmpW'(1)) >= dur;

    if (st.phase != PH_IDLE) begin
      busy = 1'b1;
      case (st.phase)
        PH_RST_LOW, PH_W_LOW, PH_R_LOW: drive = 1'b1;
        PH_W_HOLD:                      drive = ~st.shift_byte[0];
        default:                        drive = 1'b0;
      endcase

      if (phase_end) begin
        tmr = '0;
        case (st.phase)
          PH_RST_REL: st.phase = PH_RST_LOW;
          PH_RST_LOW: st.phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            st.presence = ~line_in_i;
            st.phase    = PH_IDLE;
            done        = 1'b1;
          end
          PH_W_LOW:  st.phase = PH_W_HOLD;
          PH_W_HOLD: st.phase = PH_W_REC;
          PH_W_REC: begin
            st.shift_byte = {1'b0, st.shift_byte[7:1]};
            if (st.bit_index == 3'd7) begin
              st.phase = PH_IDLE;
              done     = 1'b1;
            end else begin
              st.bit_index = st.bit_index + 3'd1;
              st.phase     = PH_W_LOW;
            end
          end
          PH_R_LOW: st.phase = PH_R_WAIT;
          PH_R_WAIT: begin
            st.shift_byte = {line_in_i, st.shift_byte[7:1]};
            st.phase      = PH_R_TAIL;
          end
          default: begin
            if (st.bit_index == 3'd7) begin
              st.read_result = st.shift_byte;
              st.phase       = PH_IDLE;
              done           = 1'b1;
            end else begin
              st.bit_index = st.bit_index + 3'd1;
              st.phase     = PH_R_LOW;
            end
          end
        endcase
      end else begin
        tmr = tmr + TIMER_BITS'(1);
      end
    end
  end

  assign state_o = st;
  assign timer_o = tmr;

  always_comb begin
    result_o.drive_low = drive;
    result_o.busy_res  = busy;
    result_o.done_res  = done;
    result_o.read_data = st.read_result;
    result_o.presence  = st.presence;
  end

endmodule

// ===== hdl/owm_skid.sv =====
module owm_skid #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [WIDTH-1:0] s_data_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [WIDTH-1:0] m_data_o
);

  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_data_q, out_data_d;
  logic             skid_valid_q, skid_valid_d;
  logic [WIDTH-1:0] skid_data_q, skid_data_d;

  assign s_ready_o = ~skid_valid_q;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;

    if (out_valid_q && m_ready_i) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end

    // the skid stage only fills when the output register stays occupied
    if (s_valid_i && ~skid_valid_q) begin
      if (out_valid_d) begin
        skid_data_d  = s_data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_data_d  = s_data_i;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

// ===== hdl/one_wire_master_timing.sv =====
// One-wire bus master timing engine.
// Each transfer on the input stream is one microsecond tick of the bus. tuser carries
// the command (tick only, reset and presence, write byte, read byte), tdata the byte to
// write and the sampled bus level. A command is taken only while the engine is idle and
// the tick that carries it is already its first tick; commands during a busy period,
// including its last tick, are dropped.
// Every input transfer gives exactly one output transfer: line drive, busy, a done pulse
// on the last tick of a command, the last read byte and the presence flag.
// The engine state and the result register update in the cycle the tick is accepted,
// and a new tick is taken every cycle while s_axis_tready is high.
// A two-entry output stage (result register plus skid register) lets the engine take
// one more tick while a result waits; with both entries full, s_axis_tready drops until
// the receiver takes a result, and the bus timing simply pauses.
// The timing registers sit on the APB port, one per word; write them while idle.
// Reset returns the engine to idle, clears presence and the read byte, empties the
// output stage and loads the default durations.
module one_wire_master_timing #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] write_data, [8] line_in, [15:9] zero
  input  logic [owm_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] op
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data, [11] presence, [15:12] zero
  output logic [owm_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [owm_pkg::AddrW-1:0]        paddr,
  input  logic [owm_pkg::ApbDataW-1:0]     pwdata,
  output logic [owm_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready
);
  import owm_pkg::*;

  cfg_t                  cfg_q;
  logic [RegIdxW-1:0]    reg_idx;
  eng_state_t            state_q, state_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  result_t               result;
  logic                  in_xfer;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign prdata  = ApbDataW'(cfg_q[reg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (psel && penable && pwrite && pready) begin
      cfg_q[reg_idx] <= pwdata[CfgW-1:0];
    end
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  owm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .state_i      (state_q),
    .timer_i      (timer_q),
    .cfg_i        (cfg_q),
    .op_i         (s_axis_tuser),
    .write_data_i (s_axis_tdata[7:0]),
    .line_in_i    (s_axis_tdata[8]),
    .state_o      (state_d),
    .timer_o      (timer_d),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, bit_index: 3'd0, shift_byte: 8'h00,
                   read_result: 8'h00, presence: 1'b0};
      timer_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
      timer_q <= timer_d;
    end
  end

  owm_skid #(
    .WIDTH (OutDataW)
  ) u_skid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (OutDataW'(result)),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule
